// File: rtl/tcu_pkg.sv
package tcu_pkg;

  localparam int MaxUnit = 56;
  localparam int CpW     = 21;
  localparam int SymW    = 7;
  localparam int FillW   = 6;
  localparam int NCand   = 3;
  localparam int NSym    = 4;

  typedef enum logic [2:0] {
    REG_VERSION_MODE  = 3'd0,
    REG_ALPHA_LOW     = 3'd1,
    REG_ALPHA_HIGH    = 3'd2,
    REG_KEEPS_UPPER   = 3'd3,
    REG_PAD_SYMBOL    = 3'd4,
    REG_UNIT_SIZE     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic             version_mode;
    logic [127:0]     alphabet;
    logic             keeps_uppercase;
    logic [SymW-1:0]  pad_symbol;
    logic [FillW-1:0] unit_size;
  } cfg_t;

  typedef struct packed {
    logic [NSym-1:0][SymW-1:0] sym;
    logic [2:0]                cnt;
  } sym_list_t;

  // Latin fold, U+00C0..U+017F, two chars per entry, space is filler
  localparam logic [8*384-1:0] LatinRom = {
    "A A A A A A AEC E E E E I I I I ",
    "D N O O O O O   O U U U U Y THss",
    "a a a a a a aec e e e e i i i i ",
    "d n o o o o o   o u u u u y thy ",
    "A a A a A a C c C c C c C c D d ",
    "D d E e E e E e E e E e G g G g ",
    "G g G g H h H h I i I i I i I i ",
    "I i IJijJ j K k k L l L l L l L ",
    "l L l N n N n N n n N n O o O o ",
    "O o OEoeR r R r R r S s S s S s ",
    "S s T t T t T t U u U u U u U u ",
    "U u U u W w Y y Y Z z Z z Z z s "
  };

  localparam logic [SymW-1:0] ChSpace = 7'h20;
  localparam logic [SymW-1:0] ChQuote = 7'h22;
  localparam logic [SymW-1:0] ChApos  = 7'h27;
  localparam logic [SymW-1:0] ChDash  = 7'h2D;
  localparam logic [SymW-1:0] ChDot   = 7'h2E;

endpackage

// File: rtl/tcu_decode.sv
module tcu_decode (
  input  logic [tcu_pkg::CpW-1:0] cp,
  input  tcu_pkg::cfg_t           cfg,
  input  logic                    started,
  input  logic                    pending,
  output tcu_pkg::sym_list_t      syms,
  output logic                    started_nxt,
  output logic                    pending_nxt
);

  logic [tcu_pkg::NCand-1:0][tcu_pkg::CpW-1:0] cand;
  logic [1:0]                                   ncand;
  logic                                         ws;
  logic [7:0]                                   lidx;
  logic [7:0]                                   lc0;
  logic [7:0]                                   lc1;
  logic                                         xhit;
  logic [tcu_pkg::SymW-1:0]                     xch;

  function automatic logic in_alpha(input logic [tcu_pkg::CpW-1:0] c,
                                    input logic [127:0] a);
    logic r;
    r = 1'b0;
    if (c < 21'd128) r = a[c[6:0]];
    return r;
  endfunction

  always_comb begin
    xhit = 1'b1;
    xch  = tcu_pkg::ChDash;
    unique case (cp)
      21'h00AB, 21'h00BB, 21'h201C, 21'h201D, 21'h201E, 21'h2033: xch = tcu_pkg::ChQuote;
      21'h02BC, 21'h2018, 21'h2019, 21'h2032:                     xch = tcu_pkg::ChApos;
      21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2015,
      21'h2212:                                                   xch = tcu_pkg::ChDash;
      21'h2026:                                                   xch = tcu_pkg::ChDot;
      default:                                                    xhit = 1'b0;
    endcase
  end

  always_comb begin
    lidx = 8'(cp - 21'h00C0);
    lc0  = tcu_pkg::LatinRom[8*(383 - 2*int'(lidx)) +: 8];
    lc1  = tcu_pkg::LatinRom[8*(382 - 2*int'(lidx)) +: 8];
  end

  always_comb begin
    ws = (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20 || cp == 21'hA0;
    cand  = '0;
    ncand = 2'd1;
    cand[0] = cp;
    if (ws) begin
      cand[0] = in_alpha(cp, cfg.alphabet) ? cp : 21'(tcu_pkg::ChSpace);
      if (cp == 21'h0D && cfg.alphabet[10]) ncand = 2'd0;
    end else if (cfg.version_mode) begin
      if (xhit) begin
        cand[0] = 21'(xch);
        if (cp == 21'h2026) begin
          cand[1] = 21'(xch);
          cand[2] = 21'(xch);
          ncand   = 2'd3;
        end
      end else if (cp >= 21'h00C0 && cp <= 21'h017F && lc0 != 8'h20) begin
        cand[0] = 21'(lc0);
        cand[1] = 21'(lc1);
        ncand   = (lc1 != 8'h20) ? 2'd2 : 2'd1;
      end
    end
  end

  always_comb begin
    logic [tcu_pkg::CpW-1:0]  c;
    logic [tcu_pkg::SymW-1:0] k;
    logic                     use_k;
    logic                     ts;
    logic                     sp;
    syms = '0;
    ts   = started;
    sp   = pending;
    for (int i = 0; i < tcu_pkg::NCand; i++) begin
      c     = cand[i];
      k     = tcu_pkg::ChSpace;
      use_k = 1'b0;
      if (2'(i) < ncand) begin
        if (!cfg.keeps_uppercase && c >= 21'h41 && c <= 21'h5A) c = c + 21'h20;
        if (in_alpha(c, cfg.alphabet)) begin
          k     = c[6:0];
          use_k = 1'b1;
        end else if (cfg.version_mode && c != 21'(tcu_pkg::ChApos)) begin
          use_k = 1'b1;
        end
      end
      if (use_k) begin
        if (k == tcu_pkg::ChSpace) begin
          if (ts) sp = 1'b1;
        end else begin
          if (sp) begin
            syms.sym[syms.cnt[1:0]] = tcu_pkg::ChSpace;
            syms.cnt = syms.cnt + 3'd1;
            sp = 1'b0;
          end
          syms.sym[syms.cnt[1:0]] = k;
          syms.cnt = syms.cnt + 3'd1;
          ts = 1'b1;
        end
      end
    end
    started_nxt = ts;
    pending_nxt = sp;
  end

endmodule

// File: rtl/text_canonicaliser_unit_chunker_core.sv
// Canonicalises a stream of codepoints into ASCII symbols cut into units.
// With the output free, an item's symbols leave one per cycle, and one
// codepoint is taken per cycle if each yields at most one symbol. An item
// (up to four symbols, plus pad symbols after a final one) holds the input until
// sent. The user must write configuration through cfg_* while idle (unchecked).
module text_canonicaliser_unit_chunker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] codepoint
  input  logic        in_tlast,   // is_final
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] symbol
  output logic        out_tuser,  // unit_end
  output logic        out_tlast,  // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  tcu_pkg::cfg_t      cfg_r;
  logic               started_r, pending_r;
  logic               started_d, pending_d;
  tcu_pkg::sym_list_t syms_d;
  tcu_pkg::sym_list_t cur_r;
  logic               cur_valid_r, cur_fin_r;
  logic [2:0]         idx_r, idx_nxt;
  logic [tcu_pkg::FillW-1:0] fill_r, fill_nxt, fill_inc, lim;
  logic               slot_free, emit, done, unit_end, last, in_acc;
  logic [tcu_pkg::SymW-1:0] sym;

  assign cfg_ready = 1'b1;

  tcu_decode u_dec (
    .cp          (in_tdata[20:0]),
    .cfg         (cfg_r),
    .started     (started_r),
    .pending     (pending_r),
    .syms        (syms_d),
    .started_nxt (started_d),
    .pending_nxt (pending_d)
  );

  always_comb begin
    if (cfg_r.unit_size == '0)                         lim = 6'd1;
    else if (cfg_r.unit_size > 6'(tcu_pkg::MaxUnit))   lim = 6'(tcu_pkg::MaxUnit);
    else                                               lim = cfg_r.unit_size;
    slot_free = !out_tvalid || out_tready;
    fill_inc  = fill_r + 6'd1;
    unit_end  = fill_inc >= lim;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    emit      = 1'b0;
    done      = 1'b0;
    last      = 1'b0;
    sym       = cfg_r.pad_symbol;
    if (cur_valid_r) begin
      if (idx_r < cur_r.cnt) begin
        sym  = cur_r.sym[idx_r[1:0]];
        last = (idx_r + 3'd1 == cur_r.cnt) && !(cur_fin_r && !unit_end);
        if (slot_free) begin
          emit     = 1'b1;
          idx_nxt  = idx_r + 3'd1;
          fill_nxt = unit_end ? '0 : fill_inc;
          done     = last;
        end
      end else if (cur_fin_r && fill_r != '0) begin
        last = unit_end;
        if (slot_free) begin
          emit     = 1'b1;
          fill_nxt = unit_end ? '0 : fill_inc;
          done     = last;
        end
      end else begin
        done = 1'b1;
      end
    end
    in_tready = !cur_valid_r || done;
    in_acc    = in_tvalid && in_tready;
    if (in_acc) idx_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.version_mode    <= 1'b1;
      cfg_r.alphabet        <= '0;
      cfg_r.keeps_uppercase <= 1'b0;
      cfg_r.pad_symbol      <= 7'h20;
      cfg_r.unit_size       <= 6'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tcu_pkg::REG_VERSION_MODE: cfg_r.version_mode    <= cfg_data[0];
        tcu_pkg::REG_ALPHA_LOW:    cfg_r.alphabet[63:0]  <= cfg_data;
        tcu_pkg::REG_ALPHA_HIGH:   cfg_r.alphabet[127:64] <= cfg_data;
        tcu_pkg::REG_KEEPS_UPPER:  cfg_r.keeps_uppercase <= cfg_data[0];
        tcu_pkg::REG_PAD_SYMBOL:   cfg_r.pad_symbol      <= cfg_data[6:0];
        tcu_pkg::REG_UNIT_SIZE:    cfg_r.unit_size       <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      pending_r   <= 1'b0;
      cur_valid_r <= 1'b0;
      cur_fin_r   <= 1'b0;
      idx_r       <= '0;
      fill_r      <= '0;
      out_tvalid  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
      if (in_acc) begin
        cur_valid_r <= 1'b1;
        cur_fin_r   <= in_tlast;
        started_r   <= in_tlast ? 1'b0 : started_d;
        pending_r   <= in_tlast ? 1'b0 : pending_d;
      end else if (done) begin
        cur_valid_r <= 1'b0;
      end
      if (emit)            out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) cur_r <= syms_d;
    if (emit) begin
      out_tdata <= {1'b0, sym};
      out_tuser <= unit_end;
      out_tlast <= last;
    end
  end

endmodule

// File: rtl/tcu_checker.sv
module tcu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_sym7: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("symbol wider than seven bits");

endmodule

bind text_canonicaliser_unit_chunker_core tcu_checker u_tcu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
